// ===== rtl/core/bdpe_pkg.sv =====
// Package for the bounded path enumerator: sizes, register indexes and
// shared controller/datapath command and status types. No dependencies.
package bdpe_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int MAX_HOPS_DEF  = 6;
    localparam int MAX_CAND_DEF  = 16;
    localparam int NODE_FIELDS   = 7;
    localparam int NODE_W        = 5;
    localparam int HOP_W         = 3;

    // configuration register indexes
    localparam logic [1:0] REG_NUM_TOR   = 2'd0;
    localparam logic [1:0] REG_MAX_HOPS  = 2'd1;
    localparam logic [1:0] REG_MAX_CAND  = 2'd2;
    localparam logic [1:0] REG_FORCE_DIR = 2'd3;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LINK_WR,
        OP_QUERY_INIT,
        OP_DIRECT,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_SORT_STEP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic query_ok;
        logic direct_only;
        logic walk_done;
        logic sort_done;
        logic emit_last;
        logic none_found;
    } dp_stat_t;

endpackage

// ===== rtl/core/bdpe_ctrl.sv =====
// Controller state machine for the path enumerator.
// Depends on bdpe_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module bdpe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                in_query,
    input  logic                out_free,
    input  bdpe_pkg::dp_stat_t  stat,
    output bdpe_pkg::dp_cmd_t   cmd,
    output logic                in_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_DIRECT, S_WALK, S_SORT, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = bdpe_pkg::OP_NONE;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_query) begin
                        cmd.op     = bdpe_pkg::OP_QUERY_INIT;
                        state_next = S_INIT;
                    end else begin
                        cmd.op = bdpe_pkg::OP_LINK_WR;
                    end
                end
            end
            S_INIT: begin
                if (stat.query_ok) begin
                    cmd.op     = bdpe_pkg::OP_DIRECT;
                    state_next = S_DIRECT;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIRECT: begin
                if (stat.direct_only) begin
                    state_next = S_SORT;
                end else begin
                    cmd.op     = bdpe_pkg::OP_WALK_START;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_SORT;
                end else begin
                    cmd.op = bdpe_pkg::OP_WALK_STEP;
                end
            end
            S_SORT: begin
                if (stat.sort_done) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.op = bdpe_pkg::OP_SORT_STEP;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.op = bdpe_pkg::OP_EMIT;
                    if (stat.emit_last || stat.none_found) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ===== rtl/core/bdpe_dp.sv =====
// Datapath of the path enumerator: link bitmap, walk stack, found-path
// table, insertion sort and result register. Depends on bdpe_pkg.
module bdpe_dp #(
    parameter int MAX_NODES = bdpe_pkg::MAX_NODES_DEF,
    parameter int MAX_HOPS  = bdpe_pkg::MAX_HOPS_DEF,
    parameter int MAX_CAND  = bdpe_pkg::MAX_CAND_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bdpe_pkg::dp_cmd_t           cmd,
    output bdpe_pkg::dp_stat_t          stat,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_idx,
    input  logic [5:0]                  cfg_val,
    input  logic [bdpe_pkg::NODE_W-1:0] row_node,
    input  logic [bdpe_pkg::NODE_W-1:0] col_node,
    input  logic                        link_up,
    input  logic [bdpe_pkg::NODE_W-1:0] src_node,
    input  logic [bdpe_pkg::NODE_W-1:0] dst_node,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [bdpe_pkg::HOP_W+bdpe_pkg::NODE_FIELDS*bdpe_pkg::NODE_W:0] out_data,
    output logic                        out_last
);

    localparam int NW    = bdpe_pkg::NODE_W;
    localparam int NF    = bdpe_pkg::NODE_FIELDS;
    localparam int HCAP  = (MAX_HOPS < NF - 1) ? MAX_HOPS : NF - 1;
    localparam int DEPTH = HCAP + 2;
    localparam int DW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_CAND + 1);
    localparam int IW    = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int LNW   = $clog2(MAX_NODES);
    localparam int VW    = LNW + 1;
    localparam int PW    = NF * NW;

    typedef logic [PW-1:0] path_t;

    // configuration
    logic [5:0] num_tor_reg;
    logic [2:0] max_hops_reg;
    logic [4:0] max_cand_reg;
    logic       force_dir_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_tor_reg   <= 6'd32;
            max_hops_reg  <= 3'd3;
            max_cand_reg  <= 5'd8;
            force_dir_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                bdpe_pkg::REG_NUM_TOR:   num_tor_reg   <= cfg_val;
                bdpe_pkg::REG_MAX_HOPS:  max_hops_reg  <= cfg_val[2:0];
                bdpe_pkg::REG_MAX_CAND:  max_cand_reg  <= cfg_val[4:0];
                bdpe_pkg::REG_FORCE_DIR: force_dir_reg <= cfg_val[0];
                default: ;
            endcase
        end
    end

    // clamped limits, latched per query
    logic [VW-1:0] n_reg;
    logic [2:0]    hops_reg;
    logic [CW-1:0] cands_reg;
    logic [NW-1:0] s_reg, t_reg;
    logic          ok_reg;

    logic [MAX_NODES-1:0] link_map_reg [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg;
    logic [NW-1:0]        stack_reg [DEPTH];
    logic [VW-1:0]        nbr_reg [DEPTH];
    logic [DW-1:0]        depth_reg;
    logic                 enter_reg;
    logic                 walk_done_reg;
    path_t                paths_reg [MAX_CAND];
    logic [2:0]           lens_reg [MAX_CAND];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        si_reg, sk_reg;
    logic [CW-1:0]        ek_reg;

    function automatic logic link_at(input logic [MAX_NODES-1:0] row, input logic [NW-1:0] b);
        logic r;
        r = 1'b0;
        if (32'(b) < MAX_NODES) r = row[b[LNW-1:0]];
        return r;
    endfunction

    // current walk frame
    logic [NW-1:0]        u;
    logic [MAX_NODES-1:0] urow;
    logic [DW-1:0]        d;
    assign d    = depth_reg;
    assign u    = stack_reg[d];
    assign urow = (32'(u) < MAX_NODES) ? link_map_reg[u[LNW-1:0]] : '0;

    // first eligible neighbor at or above next_neighbor
    logic          nb_hit;
    logic [VW-1:0] nb_v;
    always_comb begin
        nb_hit = 1'b0;
        nb_v   = '0;
        for (int v = MAX_NODES - 1; v >= 0; v--) begin
            if (VW'(v) >= nbr_reg[d] && VW'(v) < n_reg && NW'(v) != t_reg
                && !visited_reg[v] && urow[v]) begin
                nb_hit = 1'b1;
                nb_v   = VW'(v);
            end
        end
    end

    // path built from stack plus one node at position len-1
    function automatic path_t stack_path(input logic [DW-1:0] len_m1,
                                         input logic [NW-1:0] last);
        path_t p;
        p = '0;
        for (int j = 0; j < NF; j++) begin
            if (j < DEPTH && DW'(j) < len_m1) p[j*NW +: NW] = stack_reg[j];
            else if (DW'(j) == len_m1)        p[j*NW +: NW] = last;
        end
        return p;
    endfunction

    // duplicate check against table
    function automatic logic is_dup(input path_t p, input logic [2:0] l);
        logic r;
        r = 1'b0;
        for (int k = 0; k < MAX_CAND; k++)
            if (CW'(k) < count_reg && lens_reg[k] == l && paths_reg[k] == p) r = 1'b1;
        return r;
    endfunction

    logic [2:0] new_len;
    path_t      new_path;
    logic       add_en;
    logic [DW-1:0] len_m1;
    logic [NW-1:0] last_node;

    // one walk step decision
    logic u_is_t, direct_ok, full_now;
    assign u_is_t    = (u == t_reg);
    assign direct_ok = link_at(urow, t_reg) && !visited_reg[t_reg[LNW-1:0]];
    assign full_now  = (count_reg >= cands_reg);

    always_comb begin
        len_m1    = d;
        last_node = u;
        if (cmd.op == bdpe_pkg::OP_DIRECT) begin
            len_m1    = DW'(1);
            last_node = t_reg;
        end else if (enter_reg && !u_is_t) begin
            len_m1    = d + DW'(1);
            last_node = t_reg;
        end
        new_len  = 3'(len_m1);
        new_path = stack_path(len_m1, last_node);
        if (cmd.op == bdpe_pkg::OP_DIRECT) begin
            new_path          = '0;
            new_path[NW-1:0]  = s_reg;
            new_path[NW+:NW]  = t_reg;
        end
        add_en = (32'(count_reg) < MAX_CAND) && !is_dup(new_path, new_len);
    end

    // sort compare: element sk < element sk-1
    logic [IW-1:0] ka, kb;
    logic          less;
    assign ka = IW'(sk_reg);
    assign kb = IW'(sk_reg - CW'(1));
    always_comb begin
        less = 1'b0;
        if (lens_reg[ka] != lens_reg[kb]) less = lens_reg[ka] < lens_reg[kb];
        else begin
            for (int j = NF - 1; j >= 0; j--)
                if (paths_reg[ka][j*NW +: NW] != paths_reg[kb][j*NW +: NW])
                    less = paths_reg[ka][j*NW +: NW] < paths_reg[kb][j*NW +: NW];
        end
    end

    assign stat.query_ok    = ok_reg;
    assign stat.direct_only = force_dir_reg && (count_reg != '0);
    assign stat.walk_done   = walk_done_reg;
    assign stat.sort_done   = (si_reg >= count_reg);
    assign stat.emit_last   = (ek_reg + CW'(1) >= count_reg);
    assign stat.none_found  = (count_reg == '0);

    logic [DW-1:0] hops_d;
    assign hops_d = DW'(hops_reg);

    // result valid: set on emit, cleared once the transfer is taken
    always_ff @(posedge aclk) begin
        if (!aresetn)                          out_valid <= 1'b0;
        else if (cmd.op == bdpe_pkg::OP_EMIT)  out_valid <= 1'b1;
        else if (out_ready)                    out_valid <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_NODES; i++) link_map_reg[i] <= '0;
            count_reg     <= '0;
            walk_done_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                bdpe_pkg::OP_LINK_WR: begin
                    if (32'(row_node) < MAX_NODES && 32'(col_node) < MAX_NODES)
                        link_map_reg[row_node[LNW-1:0]][col_node[LNW-1:0]] <= link_up;
                end
                bdpe_pkg::OP_QUERY_INIT: begin
                    logic [VW-1:0] n;
                    logic [2:0] h;
                    logic [CW-1:0] c;
                    n = (32'(num_tor_reg) > MAX_NODES) ? VW'(MAX_NODES) : VW'(num_tor_reg);
                    h = (32'(max_hops_reg) > HCAP) ? 3'(HCAP) : max_hops_reg;
                    c = (32'(max_cand_reg) > MAX_CAND) ? CW'(MAX_CAND) : CW'(max_cand_reg);
                    n_reg     <= n;
                    hops_reg  <= h;
                    cands_reg <= c;
                    s_reg     <= src_node;
                    t_reg     <= dst_node;
                    ok_reg    <= (VW'(src_node) < n) && (VW'(dst_node) < n)
                                 && h != 3'd0 && c != '0;
                    count_reg <= '0;
                    si_reg    <= CW'(1);
                    ek_reg    <= '0;
                end
                bdpe_pkg::OP_DIRECT: begin
                    if (link_at(link_map_reg[s_reg[LNW-1:0]], t_reg) && add_en) begin
                        paths_reg[IW'(count_reg)] <= new_path;
                        lens_reg[IW'(count_reg)]  <= new_len;
                        count_reg                 <= count_reg + CW'(1);
                    end
                end
                bdpe_pkg::OP_WALK_START: begin
                    visited_reg          <= MAX_NODES'(1) << s_reg[LNW-1:0];
                    stack_reg[0]         <= s_reg;
                    depth_reg            <= '0;
                    enter_reg            <= 1'b1;
                    walk_done_reg        <= 1'b0;
                end
                bdpe_pkg::OP_WALK_STEP: begin
                    logic do_pop;
                    do_pop = 1'b0;
                    if (full_now) begin
                        walk_done_reg <= 1'b1;
                    end else if (enter_reg) begin
                        enter_reg <= 1'b0;
                        if (d >= hops_d) do_pop = 1'b1;
                        else if (u_is_t) begin
                            if (add_en) begin
                                paths_reg[IW'(count_reg)] <= new_path;
                                lens_reg[IW'(count_reg)]  <= new_len;
                                count_reg                 <= count_reg + CW'(1);
                            end
                            do_pop = 1'b1;
                        end else begin
                            if (direct_ok && add_en) begin
                                paths_reg[IW'(count_reg)] <= new_path;
                                lens_reg[IW'(count_reg)]  <= new_len;
                                count_reg                 <= count_reg + CW'(1);
                            end
                            nbr_reg[d] <= '0;
                        end
                    end else if (nb_hit) begin
                        nbr_reg[d]                 <= nb_v + VW'(1);
                        stack_reg[d + DW'(1)]      <= NW'(nb_v);
                        visited_reg[nb_v[LNW-1:0]] <= 1'b1;
                        depth_reg                  <= d + DW'(1);
                        enter_reg                  <= 1'b1;
                    end else begin
                        do_pop = 1'b1;
                    end
                    if (do_pop) begin
                        if (d == '0) walk_done_reg <= 1'b1;
                        else begin
                            visited_reg[u[LNW-1:0]] <= 1'b0;
                            depth_reg               <= d - DW'(1);
                        end
                    end
                end
                bdpe_pkg::OP_SORT_STEP: begin
                    if (sk_reg != '0 && si_reg != '0 && less) begin
                        paths_reg[ka] <= paths_reg[kb];
                        paths_reg[kb] <= paths_reg[ka];
                        lens_reg[ka]  <= lens_reg[kb];
                        lens_reg[kb]  <= lens_reg[ka];
                        sk_reg        <= sk_reg - CW'(1);
                    end else begin
                        si_reg <= si_reg + CW'(1);
                        sk_reg <= si_reg + CW'(1);
                    end
                end
                bdpe_pkg::OP_EMIT: begin
                    if (count_reg == '0) begin
                        out_data <= '0;
                        out_last <= 1'b1;
                    end else begin
                        path_t p;
                        p = paths_reg[IW'(ek_reg)];
                        for (int j = 0; j < NF; j++)
                            if (3'(j) > lens_reg[IW'(ek_reg)]) p[j*NW +: NW] = '0;
                        out_data <= {p, lens_reg[IW'(ek_reg)], 1'b1};
                        out_last <= (ek_reg + CW'(1) >= count_reg);
                        ek_reg   <= ek_reg + CW'(1);
                    end
                end
                default: ;
            endcase
            if (cmd.op == bdpe_pkg::OP_QUERY_INIT) sk_reg <= CW'(1);
        end
    end

endmodule

// ===== rtl/core/bounded_dfs_path_enumerator_top.sv =====
// Top level of the bounded depth-first path enumerator.
// Depends on bdpe_pkg, bdpe_ctrl and bdpe_dp.
//
// Usage:
//   s_ channel takes link writes (req_type 0) and path queries (req_type 1).
//   A link write gives no result; writes can follow back to back. A query
//   gives 1 to MAX_CAND results on the m_ channel, sorted by hop count
//   then node order; the final one carries m_tlast. No path gives one
//   result with found 0. s_tready is low from the cycle after a query
//   transfer until its last result is issued.
//   A query runs through setup, then the walk steps (each node entry and
//   each neighbor scan or pop), then the sort steps (insertion sort,
//   count-1 advances plus one per swap, at most about MAX_CAND^2/2),
//   and then emits its first result. Further results follow one per
//   accepted m_ transfer.
//   Configuration writes on cfg_ are taken at any time, meant while idle.
//   Reset (aresetn low, synchronous) clears the link map and restores
//   register defaults. When m_tready is low the result is held and
//   the sequencer waits before emitting the next result.
module bounded_dfs_path_enumerator_top #(
    parameter int MAX_NODES = bdpe_pkg::MAX_NODES_DEF,
    parameter int MAX_HOPS  = bdpe_pkg::MAX_HOPS_DEF,
    parameter int MAX_CAND  = bdpe_pkg::MAX_CAND_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_node, col_node, link_up, src_node, dst_node
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // found, hop_count, node_0 .. node_6
    output logic        m_tlast,   // is_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    bdpe_pkg::dp_cmd_t  cmd;
    bdpe_pkg::dp_stat_t stat;
    logic               in_ready;
    logic [38:0]        res;

    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, res};

    bdpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_tvalid && in_ready),
        .in_query (s_tuser),
        .out_free (!m_tvalid || m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    bdpe_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_HOPS  (MAX_HOPS),
        .MAX_CAND  (MAX_CAND)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .row_node  (s_tdata[4:0]),
        .col_node  (s_tdata[9:5]),
        .link_up   (s_tdata[10]),
        .src_node  (s_tdata[15:11]),
        .dst_node  (s_tdata[20:16]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (res),
        .out_last  (m_tlast)
    );

endmodule

// ===== tb/bounded_dfs_path_enumerator_top_test.sv =====
// Testbench for bounded_dfs_path_enumerator_top: link writes and path queries
// checked against a local path predictor. Depends on bdpe_pkg and the RTL.
`timescale 1ns / 1ps

module bounded_dfs_path_enumerator_top_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;

    bounded_dfs_path_enumerator_top dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic [31:0] links [32];
    int unsigned p_tor, p_hops, p_cand, p_force;
    logic [39:0] exp_tdata [$];
    logic        exp_tlast [$];
    int unsigned errors;
    int unsigned send_idle_pct, recv_idle_pct;
    bit          recv_hold;

    // found paths of the current query
    logic [4:0]  fp [16][7];
    int unsigned fl [16];
    int unsigned fcnt, q_cands;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH: %s", what);
    endtask

    // appends one expected result transfer
    function automatic void expect_result(input logic [39:0] w, input logic last);
        exp_tdata.insert(exp_tdata.size(), w);
        exp_tlast.insert(exp_tlast.size(), last);
    endfunction

    function automatic void add_found(input logic [4:0] p [7], input int unsigned len);
        bit same;
        if (fcnt >= 16 || len == 0 || len > 7) return;
        for (int k = 0; k < fcnt; k++) begin
            if (fl[k] + 1 == len) begin
                same = 1;
                for (int i = 0; i < len; i++) if (fp[k][i] != p[i]) same = 0;
                if (same) return;
            end
        end
        for (int i = 0; i < 7; i++) fp[fcnt][i] = (i < len) ? p[i] : 5'd0;
        fl[fcnt] = len - 1;
        fcnt++;
    endfunction

    function automatic bit path_before(input int a, input int b);
        if (fl[a] != fl[b]) return fl[a] < fl[b];
        for (int i = 0; i <= fl[a]; i++)
            if (fp[a][i] != fp[b][i]) return fp[a][i] < fp[b][i];
        return 0;
    endfunction

    function automatic void dfs_walk(input int unsigned s, t, n, hops);
        logic [4:0]  stk [7];
        int unsigned nxt [7];
        logic [31:0] vis;
        int unsigned d, u;
        bit enter, pushed, quit;
        vis = 32'd1 << s;
        stk = '{default: 5'd0};
        stk[0] = 5'(s);
        d = 0;
        enter = 1;
        quit = 0;
        while (!quit) begin
            u = stk[d];
            pushed = 0;
            if (fcnt >= q_cands) break;
            if (enter) begin
                enter = 0;
                if (d >= hops || u == t) begin
                    if (d < hops && u == t) add_found(stk, d + 1);
                    if (d == 0) break;
                    vis[stk[d]] = 1'b0;
                    d--;
                    continue;
                end
                if (links[u][t] && !vis[t]) begin
                    stk[d + 1] = 5'(t);
                    add_found(stk, d + 2);
                    if (fcnt >= q_cands) break;
                end
                nxt[d] = 0;
            end
            for (int v = nxt[d]; v < n; v++) begin
                if (v == t || vis[v] || !links[u][v]) continue;
                nxt[d] = v + 1;
                stk[d + 1] = 5'(v);
                vis[v] = 1'b1;
                d++;
                enter = 1;
                pushed = 1;
                break;
            end
            if (pushed) continue;
            if (d == 0) break;
            vis[stk[d]] = 1'b0;
            d--;
        end
    endfunction

    // predicts the results of one input item and queues them
    function automatic void predict_item(input logic req, input logic [23:0] d);
        int unsigned s, t, n, hops;
        logic [4:0] p [7];
        logic [39:0] w;
        bit direct_only;
        if (!req) begin
            links[d[4:0]][d[9:5]] = d[10];
            return;
        end
        s = d[15:11];
        t = d[20:16];
        n = (p_tor > 32) ? 32 : p_tor;
        hops = (p_hops > 6) ? 6 : p_hops;
        q_cands = (p_cand > 16) ? 16 : p_cand;
        fcnt = 0;
        if (s < n && t < n && hops > 0 && q_cands > 0) begin
            direct_only = 0;
            if (links[s][t]) begin
                p = '{default: 5'd0};
                p[0] = 5'(s);
                p[1] = 5'(t);
                add_found(p, 2);
                direct_only = p_force != 0;
            end
            if (!direct_only) dfs_walk(s, t, n, hops);
        end
        if (fcnt == 0) begin
            expect_result('0, 1'b1);
            return;
        end
        for (int i = 1; i < fcnt; i++) begin
            for (int k = i; k > 0 && path_before(k, k - 1); k--) begin
                p = fp[k]; fp[k] = fp[k - 1]; fp[k - 1] = p;
                n = fl[k]; fl[k] = fl[k - 1]; fl[k - 1] = n;
            end
        end
        for (int k = 0; k < fcnt; k++) begin
            w = '0;
            w[0] = 1'b1;
            w[3:1] = 3'(fl[k]);
            for (int j = 0; j < 7; j++) w[4 + 5 * j +: 5] = (j <= fl[k]) ? fp[k][j] : 5'd0;
            expect_result(w, k + 1 == fcnt);
        end
    endfunction

    // sends one item with random leading idle cycles; tvalid stays up
    // after the transfer so the next item can follow directly
    task automatic send_item(input logic req, input logic [23:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= d;
        predict_item(req, d);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_write(input int r, input int c, input bit up);
        send_item(1'b0, {13'd0, up, c[4:0], r[4:0]});
    endtask

    task automatic send_query(input int s, input int t);
        send_item(1'b1, {3'd0, t[4:0], s[4:0], 11'd0});
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (exp_tdata.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (3000) @(posedge aclk);
    endtask

    // drives one register transfer; the caller drops cfg_valid afterwards
    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[5:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            bdpe_pkg::REG_NUM_TOR:   p_tor = val & 6'h3f;
            bdpe_pkg::REG_MAX_HOPS:  p_hops = val & 3'h7;
            bdpe_pkg::REG_MAX_CAND:  p_cand = val & 5'h1f;
            bdpe_pkg::REG_FORCE_DIR: p_force = val & 1;
            default: ;
        endcase
    endtask

    task automatic set_regs(input int unsigned tor, hops, cand, force_d);
        drain();
        write_reg(bdpe_pkg::REG_NUM_TOR, tor);
        write_reg(bdpe_pkg::REG_MAX_HOPS, hops);
        write_reg(bdpe_pkg::REG_MAX_CAND, cand);
        write_reg(bdpe_pkg::REG_FORCE_DIR, force_d);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn || recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_tdata.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                if (m_tdata !== exp_tdata[0])
                    report_mismatch($sformatf("tdata %h expected %h", m_tdata, exp_tdata[0]));
                if (m_tlast !== exp_tlast[0])
                    report_mismatch($sformatf("tlast %b expected %b", m_tlast, exp_tlast[0]));
                void'(exp_tdata.pop_front());
                void'(exp_tlast.pop_front());
            end
        end
    end

    task automatic test_directed();
        send_query(0, 0);
        send_query(31, 0);
        send_write(0, 0, 1);
        send_query(0, 0);
        send_write(0, 31, 1);
        send_query(0, 31);
        send_write(0, 1, 1);
        send_write(1, 31, 1);
        send_write(1, 2, 1);
        send_write(2, 31, 1);
        send_write(31, 31, 1);
        send_write(2, 2, 0);
        send_query(0, 31);
        send_query(31, 31);
        send_query(2, 1);
        set_regs(32, 3, 8, 1);
        send_query(0, 31);
        send_query(0, 2);
        set_regs(31, 0, 8, 0);
        send_query(0, 1);
        set_regs(31, 7, 0, 0);
        send_query(0, 1);
        set_regs(63, 7, 31, 0);
        send_query(0, 31);
        send_write(0, 0, 0);
        send_query(0, 0);
    endtask

    task automatic test_random(input int count, input int unsigned nodes);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 55)
                send_write($urandom_range(nodes - 1), $urandom_range(nodes - 1),
                           1'($urandom_range(1)));
            else if (r < 60)
                send_item(1'b0, 24'($urandom));
            else if (r < 95)
                send_query($urandom_range(nodes - 1), $urandom_range(nodes - 1));
            else
                send_item(1'b1, 24'($urandom));
        end
    endtask

    task automatic test_backpressure();
        recv_hold = 1;
        fork
            begin
                repeat (400) @(posedge aclk);
                recv_hold = 0;
            end
            begin
                for (int i = 0; i < 6; i++) send_query($urandom_range(5), $urandom_range(5));
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        join
    endtask

    initial begin
        for (int i = 0; i < 32; i++) links[i] = '0;
        p_tor = 32; p_hops = 3; p_cand = 8; p_force = 0;
        errors = 0;
        recv_hold = 0;
        send_idle_pct = 37;
        recv_idle_pct = 64;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_regs(6, 6, 16, 0);
        test_random(90, 8);
        test_backpressure();
        send_idle_pct = 64;
        recv_idle_pct = 37;
        set_regs(8, 4, 5, 1);
        test_random(90, 10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(32, 1, 1, 0);
        test_random(40, 32);
        set_regs(12, 3, 16, 0);
        test_random(42, 12);
        drain();
        if (errors == 0 && exp_tdata.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/bdpe_pkg.sv
rtl/core/bdpe_ctrl.sv
rtl/core/bdpe_dp.sv
rtl/core/bounded_dfs_path_enumerator_top.sv
tb/bounded_dfs_path_enumerator_top_test.sv
